// ----- sv/imt_pkg.sv -----
`default_nettype none

package imt_pkg;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] EV_CONTENT   = 2'd0;
  localparam logic [1:0] EV_FIELD_END = 2'd1;
  localparam logic [1:0] EV_MSG_END   = 2'd2;

  localparam logic [1:0] FK_PREFIX   = 2'd0;
  localparam logic [1:0] FK_CMD      = 2'd1;
  localparam logic [1:0] FK_MIDDLE   = 2'd2;
  localparam logic [1:0] FK_TRAILING = 2'd3;

  // Most results one line-final byte can cause.
  localparam int unsigned MaxRes = 5;
  localparam int unsigned ResW   = $clog2(MaxRes + 1);

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_PREFIX,
    PH_CMD_START,
    PH_CMD,
    PH_PARAM_START,
    PH_MIDDLE,
    PH_TRAILING
  } phase_t;

  typedef struct packed {
    logic [1:0] ev_kind;
    logic [1:0] fld;
    logic [7:0] idx;
    logic [7:0] data;
  } event_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] param_count;
  } parse_st_t;

  typedef struct packed {
    parse_st_t st;
    logic      emit;
    event_t    ev;
  } step_t;

  localparam parse_st_t ST_RESET = '{phase: PH_LINE_START, param_count: 8'd0};

  function automatic event_t mk_ev(logic [1:0] kind, logic [1:0] fld, logic [7:0] idx,
                                   logic [7:0] data);
    event_t e;
    e.ev_kind = kind;
    e.fld     = fld;
    e.idx     = idx;
    e.data    = data;
    return e;
  endfunction

  // One byte through the tokenizer: next state and at most one event.
  function automatic step_t take_byte(parse_st_t st, logic [7:0] b);
    step_t      r;
    logic [7:0] inc;
    r.st   = st;
    r.emit = 1'b0;
    r.ev   = '0;
    inc    = (st.param_count == 8'hFF) ? st.param_count : st.param_count + 8'd1;
    unique case (st.phase)
      PH_PREFIX: begin
        r.emit = 1'b1;
        if (b == CH_SPACE) begin
          r.ev       = mk_ev(EV_FIELD_END, FK_PREFIX, 8'd0, 8'd0);
          r.st.phase = PH_CMD_START;
        end else begin
          r.ev = mk_ev(EV_CONTENT, FK_PREFIX, 8'd0, b);
        end
      end
      PH_CMD_START, PH_CMD: begin
        r.emit = 1'b1;
        if (b == CH_SPACE) begin
          r.ev       = mk_ev(EV_FIELD_END, FK_CMD, 8'd0, 8'd0);
          r.st.phase = PH_PARAM_START;
        end else begin
          r.ev       = mk_ev(EV_CONTENT, FK_CMD, 8'd0, b);
          r.st.phase = PH_CMD;
        end
      end
      PH_PARAM_START: begin
        if (b == CH_COLON) begin
          r.st.phase = PH_TRAILING;
        end else if (b == CH_SPACE) begin
          r.emit           = 1'b1;
          r.ev             = mk_ev(EV_FIELD_END, FK_MIDDLE, st.param_count, 8'd0);
          r.st.param_count = inc;
        end else begin
          r.emit     = 1'b1;
          r.ev       = mk_ev(EV_CONTENT, FK_MIDDLE, st.param_count, b);
          r.st.phase = PH_MIDDLE;
        end
      end
      PH_MIDDLE: begin
        r.emit = 1'b1;
        if (b == CH_SPACE) begin
          r.ev             = mk_ev(EV_FIELD_END, FK_MIDDLE, st.param_count, 8'd0);
          r.st.param_count = inc;
          r.st.phase       = PH_PARAM_START;
        end else begin
          r.ev = mk_ev(EV_CONTENT, FK_MIDDLE, st.param_count, b);
        end
      end
      PH_TRAILING: begin
        r.emit = 1'b1;
        r.ev   = mk_ev(EV_CONTENT, FK_TRAILING, st.param_count, b);
      end
      default: begin
        // Line start, and any unused code treated the same way.
        if (b == CH_COLON) begin
          r.st.phase = PH_PREFIX;
        end else if (b == CH_SPACE) begin
          r.emit     = 1'b1;
          r.ev       = mk_ev(EV_FIELD_END, FK_CMD, 8'd0, 8'd0);
          r.st.phase = PH_PARAM_START;
        end else begin
          r.emit     = 1'b1;
          r.ev       = mk_ev(EV_CONTENT, FK_CMD, 8'd0, b);
          r.st.phase = PH_CMD;
        end
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/imt_expand.sv -----
`default_nettype none

module imt_expand import imt_pkg::*; (
  input  wire parse_st_t        st,
  input  wire logic [7:0]       held0,
  input  wire logic [7:0]       held1,
  input  wire logic [1:0]       held_count,
  input  wire logic [7:0]       in_byte,
  input  wire logic             end_of_line,
  output parse_st_t             st_next,
  output event_t                res [MaxRes],
  output logic [ResW-1:0]       n_res
);

  logic [7:0] line [3];
  logic [1:0] nl;
  parse_st_t  s;
  step_t      stp;
  event_t     slot [MaxRes];
  logic       slot_v [MaxRes];
  logic [ResW-1:0] k;

  always_comb begin
    line[0] = held0;
    line[1] = held1;
    line[2] = in_byte;
    nl      = 2'd0;
    s       = st;
    stp     = '0;
    for (int i = 0; i < MaxRes; i++) begin
      slot[i]   = '0;
      slot_v[i] = 1'b0;
      res[i]    = '0;
    end

    if (!end_of_line) begin
      // Only a full delay line releases a byte to the tokenizer.
      if (held_count == 2'd2) begin
        stp       = take_byte(st, held0);
        s         = stp.st;
        slot[0]   = stp.ev;
        slot_v[0] = stp.emit;
      end
      st_next = s;
    end else begin
      unique case (held_count)
        2'd0: begin
          line[0] = in_byte;
          nl      = 2'd1;
        end
        2'd1: begin
          line[1] = in_byte;
          nl      = 2'd2;
        end
        default: nl = 2'd3;
      endcase
      if (line[nl - 2'd1] == CH_LF) nl = nl - 2'd1;
      if (nl != 2'd0 && line[nl - 2'd1] == CH_CR) nl = nl - 2'd1;

      for (int i = 0; i < 3; i++) begin
        if (2'(i) < nl) begin
          stp       = take_byte(s, line[i]);
          s         = stp.st;
          slot[i]   = stp.ev;
          slot_v[i] = stp.emit;
        end
      end

      slot_v[3] = 1'b1;
      unique case (s.phase)
        PH_PREFIX:   slot[3] = mk_ev(EV_FIELD_END, FK_PREFIX, 8'd0, 8'd0);
        PH_CMD:      slot[3] = mk_ev(EV_FIELD_END, FK_CMD, 8'd0, 8'd0);
        PH_MIDDLE:   slot[3] = mk_ev(EV_FIELD_END, FK_MIDDLE, s.param_count, 8'd0);
        PH_TRAILING: slot[3] = mk_ev(EV_FIELD_END, FK_TRAILING, s.param_count, 8'd0);
        default:     slot_v[3] = 1'b0;
      endcase
      slot[4]   = mk_ev(EV_MSG_END, FK_PREFIX, 8'd0, 8'd0);
      slot_v[4] = 1'b1;
      st_next   = ST_RESET;
    end

    // Pack the events that were really produced, in order.
    k = '0;
    for (int i = 0; i < MaxRes; i++) begin
      if (slot_v[i]) begin
        res[k[2:0]] = slot[i];
        k           = k + ResW'(1);
      end
    end
    n_res = k;
  end

endmodule

`default_nettype wire

// ----- sv/irc_message_tokenizer.sv -----
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------------------------------
// input    | in_valid, in_ready | in_byte[7:0], end_of_line
// output   | out_valid,out_ready| event_kind[1:0], field_kind[1:0], param_index[7:0],
//          |                    | out_byte[7:0], last_of_run
//
// One byte is taken per cycle into an input register while in_ready is high; its
// results are then loaded into a five-entry result buffer once it is free and leave
// one per cycle while out_ready is high. A byte in the middle of a line yields at
// most one result, so the rate is one byte per cycle while the output is ready; the
// final byte of a line can cause five results, which leave one at a time and stall
// the input until the last of them leaves. A result passes through the input
// register and then the result buffer before it is presented.
// Reset (rst, synchronous) empties both registers and returns the tokenizer to line
// start. A stalled output holds the buffer, and the input register then fills and stalls.
`default_nettype none

module irc_message_tokenizer import imt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_line,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      event_kind,
  output logic [1:0]      field_kind,
  output logic [7:0]      param_index,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);

  logic            ir_valid;
  logic [7:0]      ir_byte;
  logic            ir_eol;
  parse_st_t       st;
  parse_st_t       st_next;
  logic [7:0]      held0;
  logic [7:0]      held1;
  logic [1:0]      held_count;
  event_t          res_q [MaxRes];
  event_t          res_next [MaxRes];
  logic [ResW-1:0] n_res;
  logic [ResW-1:0] cnt;
  logic [ResW-1:0] ptr;
  logic            buf_free;
  logic            load;
  event_t          cur;

  imt_expand u_expand (
    .st          (st),
    .held0       (held0),
    .held1       (held1),
    .held_count  (held_count),
    .in_byte     (ir_byte),
    .end_of_line (ir_eol),
    .st_next     (st_next),
    .res         (res_next),
    .n_res       (n_res)
  );

  assign out_valid = (ptr != cnt);
  assign buf_free  = (ptr == cnt) || ((ptr + ResW'(1) == cnt) && out_ready);
  assign load      = ir_valid && buf_free;
  assign in_ready  = !ir_valid || buf_free;

  assign cur         = res_q[ptr];
  assign event_kind  = cur.ev_kind;
  assign field_kind  = cur.fld;
  assign param_index = cur.idx;
  assign out_byte    = cur.data;
  assign last_of_run = (ptr + ResW'(1) == cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid   <= 1'b0;
      st         <= ST_RESET;
      held_count <= 2'd0;
      cnt        <= '0;
      ptr        <= '0;
    end else begin
      if (in_valid && in_ready) begin
        ir_valid <= 1'b1;
      end else if (load) begin
        ir_valid <= 1'b0;
      end
      if (load) begin
        st  <= st_next;
        cnt <= n_res;
        ptr <= '0;
        if (ir_eol) begin
          held_count <= 2'd0;
        end else if (held_count != 2'd2) begin
          held_count <= held_count + 2'd1;
        end
      end else if (out_valid && out_ready) begin
        ptr <= ptr + ResW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_byte <= in_byte;
      ir_eol  <= end_of_line;
    end
    if (load) begin
      res_q <= res_next;
      if (!ir_eol) begin
        if (held_count == 2'd2) begin
          held0 <= held1;
          held1 <= ir_byte;
        end else if (held_count == 2'd0) begin
          held0 <= ir_byte;
        end else begin
          held1 <= ir_byte;
        end
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= ResW'(MaxRes) && ptr <= cnt)
    else $error("result buffer count or pointer out of range");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd3)
    else $error("delay line count out of range");

  a_msg_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_MSG_END |-> last_of_run)
    else $error("message end is not the last result of its transaction");

  a_mid_line_one: assert property (@(posedge clk) disable iff (rst)
    load && !ir_eol |=> cnt <= ResW'(1))
    else $error("a byte inside the line produced more than one result");

  a_line_reset: assert property (@(posedge clk) disable iff (rst)
    load && ir_eol |=> held_count == 2'd0 && st.phase == PH_LINE_START)
    else $error("tokenizer did not return to line start after a line");

endmodule

`default_nettype wire

// ----- tb/irc_message_tokenizer_checker.sv -----
`default_nettype none

module irc_message_tokenizer_checker import imt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_line,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [1:0] event_kind,
  input  wire logic [1:0] field_kind,
  input  wire logic [7:0] param_index,
  input  wire logic [7:0] out_byte,
  input  wire logic       last_of_run,
  output int              errors,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] fld;
    logic [7:0] idx;
    logic [7:0] data;
    logic       last;
  } token_ev_t;

  token_ev_t   expected_events[$];
  token_ev_t   got_ev;
  token_ev_t   want_ev;

  // Tokenizer state as seen from the line being received.
  logic [7:0]  held [2];
  int unsigned held_n;
  phase_t      phase;
  logic [7:0]  param_cnt;

  function automatic void clear_parser();
    held_n    = 0;
    phase     = PH_LINE_START;
    param_cnt = 8'd0;
  endfunction

  function automatic void note(logic [1:0] kind, logic [1:0] fld, logic [7:0] idx,
                               logic [7:0] data);
    token_ev_t ev;
    ev = '{kind: kind, fld: fld, idx: idx, data: data, last: 1'b0};
    expected_events.insert(expected_events.size(), ev);
  endfunction

  function automatic void next_param();
    if (param_cnt != 8'hFF) param_cnt = param_cnt + 8'd1;
  endfunction

  function automatic void tokenize(logic [7:0] b);
    case (phase)
      PH_PREFIX: begin
        if (b == CH_SPACE) begin
          note(EV_FIELD_END, FK_PREFIX, 8'd0, 8'd0);
          phase = PH_CMD_START;
        end else begin
          note(EV_CONTENT, FK_PREFIX, 8'd0, b);
        end
      end
      PH_PARAM_START: begin
        if (b == CH_COLON) begin
          phase = PH_TRAILING;
        end else if (b == CH_SPACE) begin
          note(EV_FIELD_END, FK_MIDDLE, param_cnt, 8'd0);
          next_param();
        end else begin
          note(EV_CONTENT, FK_MIDDLE, param_cnt, b);
          phase = PH_MIDDLE;
        end
      end
      PH_MIDDLE: begin
        if (b == CH_SPACE) begin
          note(EV_FIELD_END, FK_MIDDLE, param_cnt, 8'd0);
          next_param();
          phase = PH_PARAM_START;
        end else begin
          note(EV_CONTENT, FK_MIDDLE, param_cnt, b);
        end
      end
      PH_TRAILING: begin
        note(EV_CONTENT, FK_TRAILING, param_cnt, b);
      end
      default: begin
        // Line start behaves as command start unless a colon opens the prefix.
        if (phase == PH_LINE_START && b == CH_COLON) begin
          phase = PH_PREFIX;
        end else if (b == CH_SPACE) begin
          note(EV_FIELD_END, FK_CMD, 8'd0, 8'd0);
          phase = PH_PARAM_START;
        end else begin
          note(EV_CONTENT, FK_CMD, 8'd0, b);
          phase = PH_CMD;
        end
      end
    endcase
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eol);
    int unsigned first;
    int unsigned n;
    logic [7:0]  line [3];
    token_ev_t   tail;
    first = expected_events.size();
    if (!eol) begin
      if (held_n == 2) begin
        tokenize(held[0]);
        held[0] = held[1];
        held[1] = b;
      end else begin
        held[held_n] = b;
        held_n++;
      end
    end else begin
      n = 0;
      for (int i = 0; i < held_n; i++) begin
        line[n] = held[i];
        n++;
      end
      line[n] = b;
      n++;
      // One LF, then one CR, come off the end before tokenizing.
      if (n > 0 && line[n-1] == CH_LF) n--;
      if (n > 0 && line[n-1] == CH_CR) n--;
      for (int i = 0; i < n; i++) tokenize(line[i]);
      case (phase)
        PH_PREFIX:   note(EV_FIELD_END, FK_PREFIX, 8'd0, 8'd0);
        PH_CMD:      note(EV_FIELD_END, FK_CMD, 8'd0, 8'd0);
        PH_MIDDLE:   note(EV_FIELD_END, FK_MIDDLE, param_cnt, 8'd0);
        PH_TRAILING: note(EV_FIELD_END, FK_TRAILING, param_cnt, 8'd0);
        default: ;
      endcase
      note(EV_MSG_END, FK_PREFIX, 8'd0, 8'd0);
      clear_parser();
    end
    if (expected_events.size() > first) begin
      tail      = expected_events[expected_events.size() - 1];
      tail.last = 1'b1;
      expected_events[expected_events.size() - 1] = tail;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_events.delete();
      clear_parser();
    end else begin
      if (in_valid && in_ready) predict_byte(in_byte, end_of_line);
      if (out_valid && out_ready) begin
        got_ev = '{kind: event_kind, fld: field_kind, idx: param_index, data: out_byte,
                   last: last_of_run};
        if (expected_events.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result kind=%0d field=%0d index=%0d byte=%02h last=%0d",
                     $realtime, got_ev.kind, got_ev.fld, got_ev.idx, got_ev.data, got_ev.last);
        end else begin
          want_ev = expected_events.pop_front();
          if (got_ev !== want_ev) begin
            errors++;
            if (errors <= 10)
              $display("%0t: expected %0d/%0d/%0d/%02h/%0d, got %0d/%0d/%0d/%02h/%0d",
                       $realtime, want_ev.kind, want_ev.fld, want_ev.idx,
                       want_ev.data, want_ev.last, got_ev.kind, got_ev.fld, got_ev.idx,
                       got_ev.data, got_ev.last);
          end
        end
      end
    end
    pending <= expected_events.size();
  end

endmodule

`default_nettype wire

// ----- tb/irc_message_tokenizer_tb.sv -----
`default_nettype none

module irc_message_tokenizer_tb;
  import imt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte     = 8'd0;
  logic       end_of_line = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [1:0] event_kind;
  logic [1:0] field_kind;
  logic [7:0] param_index;
  logic [7:0] out_byte;
  logic       last_of_run;

  int         errors;
  int         pending;

  // Run-phase flags; calm and squeeze are shared between the sender and the receiver.
  bit         calm;
  bit         squeeze;
  bit         squeeze_done;
  int         random_sent;
  logic [7:0] line_buf[$];

  always #5 clk = ~clk;

  irc_message_tokenizer DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .end_of_line (end_of_line),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .field_kind  (field_kind),
    .param_index (param_index),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  irc_message_tokenizer_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .end_of_line (end_of_line),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .field_kind  (field_kind),
    .param_index (param_index),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .errors      (errors),
    .pending     (pending)
  );

  task automatic send_byte(input logic [7:0] b, input logic eol);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    end_of_line <= eol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++)
      send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic add_byte(input logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic put_word(input int min_len, input int max_len);
    int len;
    len = $urandom_range(min_len, max_len);
    repeat (len) begin
      if ($urandom_range(0, 7) == 0) add_byte(8'($urandom_range(128, 255)));
      else add_byte(8'($urandom_range(33, 126)));
    end
  endtask

  // Mostly well-formed messages with random content; the rest is byte noise.
  task automatic build_random_line();
    int n_params;
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 1) == 1) begin
        add_byte(CH_COLON);
        put_word(1, 6);
        add_byte(CH_SPACE);
      end
      put_word(1, 5);
      n_params = $urandom_range(0, 4);
      repeat (n_params) begin
        add_byte(CH_SPACE);
        put_word(1, 5);
      end
      if ($urandom_range(0, 1) == 1) begin
        add_byte(CH_SPACE);
        add_byte(CH_COLON);
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 3))
            0:       add_byte(CH_SPACE);
            1:       add_byte(CH_COLON);
            default: add_byte(8'($urandom_range(33, 126)));
          endcase
        end
      end
      case ($urandom_range(0, 3))
        0: begin
          add_byte(CH_CR);
          add_byte(CH_LF);
        end
        1:       add_byte(CH_LF);
        2:       add_byte(CH_CR);
        default: ;
      endcase
    end else begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 4))
          0:       add_byte(CH_SPACE);
          1:       add_byte(CH_COLON);
          2:       add_byte(CH_CR);
          3:       add_byte(CH_LF);
          default: add_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty line, a full message with prefix and trailing, doubled spaces with
    // extreme bytes and an LF that is not stripped, an unclosed prefix, and a
    // command closed by a space with nothing after it.
    put_text("\n");
    send_line();
    put_text(":a b :c d\r\n");
    send_line();
    put_text("X  ");
    add_byte(8'hFF);
    add_byte(8'h00);
    put_text(" \n\r");
    send_line();
    put_text(":p");
    send_line();
    put_text("Q ");
    send_line();

    while (random_sent < 176) begin
      build_random_line();
      random_sent += line_buf.size();
      if (random_sent >= 40) squeeze = 1'b1;
      if (random_sent >= 150) calm = 1'b1;
      send_line();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: random back-pressure bursts, plus one long hold-off that lets the
  // result buffer and the input register fill while bytes keep being offered.
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (squeeze && !squeeze_done) begin
        out_ready <= 1'b0;
        repeat (64) @(posedge clk);
        squeeze_done = 1'b1;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #3ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
